@@ design/drm_pkg.sv @@
package drm_pkg;

  // Number of operation slots and the width of a slot index.
  localparam int MAX_OPS = 64;
  localparam int IDX_W   = $clog2(MAX_OPS);

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [MAX_OPS-1:0] row_t;

  // Item opcodes. The fourth code is unused and is ignored.
  typedef enum logic [1:0] {
    OPC_BEGIN = 2'd0,
    OPC_MERGE = 2'd1,
    OPC_QUERY = 2'd2
  } opcode_t;

  // One write into the row store.
  typedef struct packed {
    logic en;
    idx_t addr;
    row_t data;
  } row_wr_t;

endpackage

@@ design/dependency_reachability_matrix.sv @@
// A query passes the input stage, then the output register that drives out_connected.
// Throughput: one transaction per cycle; the row store does one read pair and one write
// per cycle, and the only stall comes from a held answer on the result side.
// Reset: synchronous, active low; clears the pipeline and output valids and marks every
// row of the reachability store as empty (all zeros) at once.
module dependency_reachability_matrix
  import drm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [5:0] in_op_index,
  input  logic [5:0] in_other_index,
  input  logic       in_self_listed,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_connected
);

  logic       s1_vld_r;
  logic [1:0] s1_opcode_r;
  idx_t       s1_op_r;
  idx_t       s1_oth_r;
  logic       s1_self_r;

  logic out_valid_r;
  logic out_connected_r;

  logic    advance;
  logic    s1_query;
  row_t    row_op;
  row_t    row_oth;
  row_wr_t wr;
  row_t    own_bit;

  // The stage holds only when a query answer cannot leave.
  assign s1_query = s1_vld_r && (s1_opcode_r == OPC_QUERY);
  assign advance  = !(s1_query && out_valid_r && out_stall);
  assign in_stall = !advance;

  // Input register stage; the row reads are taken at the same edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_opcode_r <= in_opcode;
      s1_op_r     <= in_op_index;
      s1_oth_r    <= in_other_index;
      s1_self_r   <= in_self_listed;
    end
  end

  drm_row_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (advance),
    .rd_addr_a (in_op_index),
    .rd_addr_b (in_other_index),
    .wr        (wr),
    .row_a     (row_op),
    .row_b     (row_oth)
  );

  // Row update for begin and merge transactions.
  assign own_bit = row_t'(1) << s1_op_r;

  always_comb begin
    wr.en   = 1'b0;
    wr.addr = s1_op_r;
    wr.data = row_op;
    unique case (s1_opcode_r)
      OPC_BEGIN: begin
        wr.en   = s1_vld_r;
        wr.data = (s1_self_r ? row_op : '0) | own_bit;
      end
      OPC_MERGE: begin
        // A merge of a row into itself changes nothing and is dropped.
        wr.en   = s1_vld_r && (s1_op_r != s1_oth_r);
        wr.data = row_op | row_oth;
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
  end

  // Output register holding the query answer until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_query && advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_query && advance) begin
      out_connected_r <= row_op[s1_oth_r];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_connected = out_connected_r;

endmodule

@@ design/drm_row_store.sv @@
module drm_row_store
  import drm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    rd_en,
  input  idx_t    rd_addr_a,
  input  idx_t    rd_addr_b,
  input  row_wr_t wr,
  output row_t    row_a,
  output row_t    row_b
);

  // Row storage. Rows that were never written read as zero through the valid bits.
  row_t              mem [MAX_OPS];
  logic [MAX_OPS-1:0] row_vld_r;

  row_t rd_a_r;
  row_t rd_b_r;
  logic vld_a_r;
  logic vld_b_r;
  logic fwd_a_r;
  logic fwd_b_r;
  row_t fwd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Valid bits are cleared at reset and set by the first write of each row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr.en) begin
      row_vld_r[wr.addr] <= 1'b1;
    end
  end

  // Two registered read ports. A write that lands at the same edge as the read
  // is captured for forwarding, since the array still returns the old row.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r     <= mem[rd_addr_a];
      rd_b_r     <= mem[rd_addr_b];
      vld_a_r    <= row_vld_r[rd_addr_a];
      vld_b_r    <= row_vld_r[rd_addr_b];
      fwd_a_r    <= wr.en && (wr.addr == rd_addr_a);
      fwd_b_r    <= wr.en && (wr.addr == rd_addr_b);
      fwd_data_r <= wr.data;
    end
  end

  // Select the forwarded row, the stored row, or zero for a row never written.
  assign row_a = fwd_a_r ? fwd_data_r : (vld_a_r ? rd_a_r : '0);
  assign row_b = fwd_b_r ? fwd_data_r : (vld_b_r ? rd_b_r : '0);

endmodule

@@ bench/tb_dependency_reachability_matrix.sv @@
`timescale 1ns / 1ps

module tb_dependency_reachability_matrix;
  import drm_pkg::*;

  // The fourth opcode is not decoded by the block and must be ignored.
  localparam logic [1:0] OPC_UNUSED = 2'd3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_opcode = OPC_BEGIN;
  logic [5:0] in_op_index = '0;
  logic [5:0] in_other_index = '0;
  logic       in_self_listed = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_connected;

  // Own copy of the ancestor matrix and the answers still owed by the block.
  row_t reach_rows [MAX_OPS];
  logic connected_expected [$];
  logic connected_oldest;

  int error_count = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  dependency_reachability_matrix i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_op_index   (in_op_index),
    .in_other_index(in_other_index),
    .in_self_listed(in_self_listed),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_connected (out_connected)
  );

  always #1 clk = ~clk;

  // Apply one accepted transaction to the ancestor matrix and queue any answer.
  task automatic update_reach_rows(input logic [1:0] opc, input idx_t op_idx,
                                   input idx_t other_idx, input logic self_listed);
    case (opc)
      OPC_BEGIN: begin
        if (!self_listed) begin
          reach_rows[op_idx] = '0;
        end
        reach_rows[op_idx][op_idx] = 1'b1;
      end
      OPC_MERGE: begin
        if (op_idx != other_idx) begin
          reach_rows[op_idx] = reach_rows[op_idx] | reach_rows[other_idx];
        end
      end
      OPC_QUERY: begin
        connected_expected.push_back(reach_rows[op_idx][other_idx]);
      end
      default: begin
      end
    endcase
  endtask

  // Random backpressure on the result side.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Check each accepted answer against the oldest one owed, then absorb new input.
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (reach_rows[i]) reach_rows[i] = '0;
      connected_expected.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (connected_expected.size() == 0) begin
          $error("connected: no answer expected, actual %0b", out_connected);
          error_count++;
        end else begin
          connected_oldest = connected_expected.pop_front();
          if (out_connected !== connected_oldest) begin
            $error("connected mismatch: expected %0b, actual %0b",
                   connected_oldest, out_connected);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        update_reach_rows(in_opcode, in_op_index, in_other_index, in_self_listed);
      end
    end
  end

  // Offer one transaction, with a random idle gap first, and wait until it is taken.
  task automatic send_item(input logic [1:0] opc, input idx_t op_idx,
                           input idx_t other_idx, input logic self_listed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= opc;
    in_op_index    <= op_idx;
    in_other_index <= other_idx;
    in_self_listed <= self_listed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Hold the sender off until every owed answer has come back.
  task automatic wait_for_answers();
    in_valid <= 1'b0;
    do @(posedge clk); while (connected_expected.size() != 0);
  endtask

  // A small dependency graph in topological order, with queries after each node.
  task automatic send_graph();
    idx_t chain [12];
    int   nodes;
    int   merges;
    int   queries;
    nodes = $urandom_range(12, 2);
    foreach (chain[i]) chain[i] = idx_t'($urandom_range(63));
    for (int k = 0; k < nodes; k++) begin
      send_item(OPC_BEGIN, chain[k], idx_t'($urandom), ($urandom_range(9) == 0));
      merges = (k == 0) ? 0 : $urandom_range((k < 3) ? k : 3);
      for (int m = 0; m < merges; m++) begin
        send_item(OPC_MERGE, chain[k], chain[$urandom_range(k - 1)], 1'($urandom));
      end
      // Now and then try to merge a row onto itself.
      if ($urandom_range(15) == 0) begin
        send_item(OPC_MERGE, chain[k], chain[k], 1'($urandom));
      end
      queries = $urandom_range(2);
      for (int q = 0; q < queries; q++) begin
        send_item(OPC_QUERY, chain[$urandom_range(k)], chain[$urandom_range(k)],
                  1'($urandom));
      end
    end
  endtask

  // Mostly well-formed graphs, the rest arbitrary transactions of any opcode.
  task automatic send_random_items(input int count);
    int start_count;
    start_count = items_sent;
    while (items_sent - start_count < count) begin
      if ($urandom_range(99) < 75) begin
        send_graph();
      end else begin
        send_item(2'($urandom_range(3)), idx_t'($urandom), idx_t'($urandom),
                  1'($urandom));
      end
    end
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    stall_pct     = 0;
    // Queries on the empty store answer zero, even for a slot against itself.
    send_item(OPC_QUERY, 6'd0, 6'd0, 1'b0);
    send_item(OPC_QUERY, 6'd63, 6'd63, 1'b1);
    // Open the extreme slots; other_index is ignored by begin.
    send_item(OPC_BEGIN, 6'd0, 6'd63, 1'b0);
    send_item(OPC_BEGIN, 6'd63, 6'd0, 1'b0);
    send_item(OPC_QUERY, 6'd0, 6'd0, 1'b0);
    send_item(OPC_QUERY, 6'd63, 6'd63, 1'b0);
    send_item(OPC_QUERY, 6'd63, 6'd0, 1'b0);
    // Merge a producer and see its ancestry appear; self_listed is ignored here.
    send_item(OPC_MERGE, 6'd63, 6'd0, 1'b1);
    send_item(OPC_QUERY, 6'd63, 6'd0, 1'b1);
    send_item(OPC_QUERY, 6'd0, 6'd63, 1'b0);
    // Merging a row onto itself does nothing.
    send_item(OPC_MERGE, 6'd0, 6'd0, 1'b0);
    send_item(OPC_QUERY, 6'd0, 6'd63, 1'b0);
    // A self-listed begin keeps the row, a plain begin clears it.
    send_item(OPC_BEGIN, 6'd63, 6'd63, 1'b1);
    send_item(OPC_QUERY, 6'd63, 6'd0, 1'b0);
    send_item(OPC_BEGIN, 6'd63, 6'd0, 1'b0);
    send_item(OPC_QUERY, 6'd63, 6'd0, 1'b0);
    // The unused opcode must not touch the store or answer.
    send_item(OPC_UNUSED, 6'd0, 6'd63, 1'b1);
    send_item(OPC_UNUSED, 6'd63, 6'd0, 1'b0);
    send_item(OPC_MERGE, 6'd0, 6'd63, 1'b0);
    send_item(OPC_QUERY, 6'd0, 6'd63, 1'b1);
    send_item(OPC_QUERY, 6'd63, 6'd63, 1'b0);
  endtask

  task automatic test_random_no_idle();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_random_items(212);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 85;
    stall_pct     = 0;
    send_random_items(212);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct = 0;
    stall_pct     = 85;
    send_random_items(212);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 19;
    stall_pct     = 19;
    send_random_items(212);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    wait_for_answers();
    test_random_no_idle();
    test_random_sender_idle();
    wait_for_answers();
    test_random_receiver_stall();
    test_random_both_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (connected_expected.size() != 0);
    repeat (6) @(posedge clk);
    if (error_count == 0 && connected_expected.size() == 0) begin
      $display("dependency_reachability_matrix test passed");
    end else begin
      $display("dependency_reachability_matrix test failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #400000;
    $display("dependency_reachability_matrix test failed");
    $finish;
  end

endmodule
